@@ sv/ptks_pkg.sv @@
package ptks_pkg;

  // fixed field widths
  localparam int WORD_W   = 64;
  localparam int WEIGHT_W = 31;
  localparam int LEN_W    = 4;
  localparam int TOPK_W   = 4;
  localparam int RANK_W   = 3;
  localparam int OP_W     = 2;

  localparam logic [TOPK_W-1:0] TOPK_RESET = 4'd5;

  // item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // query sequencer
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_EMIT  = 2'd3
  } state_e;

  // control from the sequencer to the ranked list
  typedef struct packed {
    logic clr;
    logic ins;
  } best_ctl_t;

endpackage

@@ sv/ptks_best.sv @@
module ptks_best #(
  parameter int MAX_K = 8,
  parameter int KW    = (MAX_K < 1) ? 1 : $clog2(MAX_K + 1),
  parameter int IW    = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ptks_pkg::best_ctl_t            ctl_i,
  input  logic [ptks_pkg::WORD_W-1:0]    cand_word_i,
  input  logic [ptks_pkg::WEIGHT_W-1:0]  cand_weight_i,
  input  logic [KW-1:0]                  k_i,
  input  logic [IW-1:0]                  rd_idx_i,
  output logic [ptks_pkg::WORD_W-1:0]    rd_word_o,
  output logic [ptks_pkg::WEIGHT_W-1:0]  rd_weight_o,
  output logic [KW-1:0]                  count_o
);

  logic [ptks_pkg::WORD_W-1:0]   slot_word_q   [MAX_K];
  logic [ptks_pkg::WEIGHT_W-1:0] slot_weight_q [MAX_K];
  logic [KW-1:0]                 count_q, count_d;
  logic [MAX_K-1:0]              gt;
  logic                          ins_ok;
  logic [IW-1:0]                 k_last;

  // candidate goes ahead of slot j (empty slots always lose)
  always_comb begin
    for (int j = 0; j < MAX_K; j++) begin
      gt[j] = (KW'(j) >= count_q)
           || (cand_weight_i > slot_weight_q[j])
           || ((cand_weight_i == slot_weight_q[j]) && (cand_word_i < slot_word_q[j]));
    end
  end

  // insert only if the candidate lands inside the first k slots
  assign k_last = IW'(k_i - KW'(1));
  assign ins_ok = ctl_i.ins && gt[k_last];

  // fill count, saturating at k
  always_comb begin
    count_d = count_q;
    if (ctl_i.clr) begin
      count_d = '0;
    end else if (ins_ok && (count_q < k_i)) begin
      count_d = count_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // sorted insert: slots from the insert point shift down by one
  always_ff @(posedge clk_i) begin
    if (ins_ok) begin
      for (int j = 0; j < MAX_K; j++) begin
        if (gt[j]) begin
          if (j == 0) begin
            slot_word_q[j]   <= cand_word_i;
            slot_weight_q[j] <= cand_weight_i;
          end else if (!gt[j-1]) begin
            slot_word_q[j]   <= cand_word_i;
            slot_weight_q[j] <= cand_weight_i;
          end else begin
            slot_word_q[j]   <= slot_word_q[j-1];
            slot_weight_q[j] <= slot_weight_q[j-1];
          end
        end
      end
    end
  end

  assign rd_word_o   = slot_word_q[rd_idx_i];
  assign rd_weight_o = slot_weight_q[rd_idx_i];
  assign count_o     = count_q;

endmodule

@@ sv/prefix_top_k_selector.sv @@
// Prefix autocomplete over a word/frequency store. Pulse start_i with busy_o
// low to hand in an item. Clear and append give no result; an append to a
// full store is dropped. A query scans every stored entry once, one store
// read per cycle, through a two-stage read/match pipe into a sorted insert
// list, and holds busy_o while it scans and emits; a query with an empty
// prefix, empty store or top_k of zero skips the scan. Results come out on
// consecutive cycles, each valid for exactly one cycle under result_valid_o,
// best first, with last_item_o on the final one; they cannot be held off.
// An empty prefix, empty store, top_k of zero or no match gives one item with
// empty_result_o set. top_k is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, the block itself does not enforce this.
module prefix_top_k_selector #(
  parameter int MAX_ENTRIES = 1024,
  parameter int MAX_CHARS   = 8,
  parameter int MAX_K       = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ptks_pkg::TOPK_W-1:0]    cfg_wdata_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [ptks_pkg::OP_W-1:0]      opcode_i,
  input  logic [ptks_pkg::WORD_W-1:0]    text_i,
  input  logic [ptks_pkg::LEN_W-1:0]     text_len_i,
  input  logic [ptks_pkg::WEIGHT_W-1:0]  weight_i,
  output logic                           result_valid_o,
  output logic [ptks_pkg::WORD_W-1:0]    match_word_o,
  output logic [ptks_pkg::WEIGHT_W-1:0]  match_weight_o,
  output logic [ptks_pkg::RANK_W-1:0]    rank_o,
  output logic                           empty_result_o,
  output logic                           last_item_o
);

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int KW    = $clog2(MAX_K + 1);
  localparam int IW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int LenW  = ptks_pkg::LEN_W;
  localparam int WordW = ptks_pkg::WORD_W;
  localparam int WtW   = ptks_pkg::WEIGHT_W;

  // entry store
  logic [WordW-1:0] word_mem   [MAX_ENTRIES];
  logic [WtW-1:0]   weight_mem [MAX_ENTRIES];

  ptks_pkg::state_e state_q, state_d;

  logic [ptks_pkg::TOPK_W-1:0] topk_q;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [IW-1:0]    emit_q, emit_d;
  logic [KW-1:0]    k_q;
  logic [WordW-1:0] prefix_q, mask_q;

  logic             accept;
  logic             query_go;
  logic             append_go;
  logic             scan_last;
  logic             skip_scan;
  logic [LenW-1:0]  len_eff;
  logic [WordW-1:0] mask_new;
  logic [KW-1:0]    k_eff;

  // read and match pipe
  logic             rv_q, mv_q;
  logic [WordW-1:0] rd_word_q, m_word_q;
  logic [WtW-1:0]   rd_wt_q, m_wt_q;

  ptks_pkg::best_ctl_t best_ctl;
  logic [WordW-1:0]    best_word;
  logic [WtW-1:0]      best_wt;
  logic [KW-1:0]       best_n;

  // emit path
  logic             emit_valid, emit_empty, emit_last;
  logic [31:0]      emit_ext;
  logic             res_valid_q, res_empty_q, res_last_q;
  logic [WordW-1:0] res_word_q;
  logic [WtW-1:0]   res_wt_q;
  logic [ptks_pkg::RANK_W-1:0] res_rank_q;

  assign busy_o    = (state_q != ptks_pkg::ST_IDLE);
  assign accept    = start_i && !busy_o;
  assign query_go  = accept && (opcode_i == ptks_pkg::OP_QUERY);
  assign append_go = accept && (opcode_i == ptks_pkg::OP_APPEND)
                  && (count_q < CW'(MAX_ENTRIES));

  // saturated prefix length and top_k
  assign len_eff = (32'(text_len_i) > MAX_CHARS) ? LenW'(MAX_CHARS) : text_len_i;
  assign k_eff   = (32'(topk_q) > MAX_K) ? KW'(MAX_K) : KW'(topk_q);

  // byte mask over the prefix, first character in the top byte
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask_new[WordW-1-8*b -: 8] = (LenW'(b) < len_eff) ? 8'hFF : 8'h00;
    end
  end

  assign skip_scan = (len_eff == '0) || (k_eff == '0) || (count_q == '0);
  assign scan_last = ((CW'(addr_q) + CW'(1)) == count_q);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topk_q <= ptks_pkg::TOPK_RESET;
    end else if (cfg_we_i) begin
      topk_q <= cfg_wdata_i;
    end
  end

  // entry count
  always_comb begin
    count_d = count_q;
    if (accept && (opcode_i == ptks_pkg::OP_CLEAR)) begin
      count_d = '0;
    end else if (append_go) begin
      count_d = count_q + CW'(1);
    end
  end

  // store write and scan read
  always_ff @(posedge clk_i) begin
    if (append_go) begin
      word_mem[count_q[AW-1:0]]   <= text_i;
      weight_mem[count_q[AW-1:0]] <= weight_i;
    end
    rd_word_q <= word_mem[addr_q];
    rd_wt_q   <= weight_mem[addr_q];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptks_pkg::ST_IDLE: begin
        if (query_go) begin
          state_d = skip_scan ? ptks_pkg::ST_EMIT : ptks_pkg::ST_SCAN;
        end
      end
      ptks_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = ptks_pkg::ST_DRAIN;
        end
      end
      ptks_pkg::ST_DRAIN: begin
        if (!rv_q && !mv_q) begin
          state_d = ptks_pkg::ST_EMIT;
        end
      end
      ptks_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_d = ptks_pkg::ST_IDLE;
        end
      end
      default: state_d = ptks_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    addr_d       = addr_q;
    emit_d       = emit_q;
    best_ctl.clr = 1'b0;
    best_ctl.ins = mv_q;
    emit_valid   = 1'b0;
    case (state_q)
      ptks_pkg::ST_IDLE: begin
        addr_d       = '0;
        emit_d       = '0;
        best_ctl.clr = query_go;
      end
      ptks_pkg::ST_SCAN: begin
        addr_d = addr_q + AW'(1);
      end
      ptks_pkg::ST_DRAIN: begin
        addr_d = '0;
      end
      ptks_pkg::ST_EMIT: begin
        emit_valid = 1'b1;
        emit_d     = emit_q + IW'(1);
      end
      default: begin
        addr_d = '0;
      end
    endcase
  end

  assign emit_empty = (best_n == '0);
  assign emit_last  = emit_empty || ((KW'(emit_q) + KW'(1)) == best_n);
  assign emit_ext   = 32'(emit_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptks_pkg::ST_IDLE;
      count_q     <= '0;
      addr_q      <= '0;
      emit_q      <= '0;
      rv_q        <= 1'b0;
      mv_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      emit_q      <= emit_d;
      rv_q        <= (state_q == ptks_pkg::ST_SCAN);
      mv_q        <= rv_q && (((rd_word_q ^ prefix_q) & mask_q) == '0);
      res_valid_q <= emit_valid;
    end
  end

  // query context, match stage and result payload
  always_ff @(posedge clk_i) begin
    if (query_go) begin
      prefix_q <= text_i;
      mask_q   <= mask_new;
      k_q      <= k_eff;
    end
    m_word_q    <= rd_word_q;
    m_wt_q      <= rd_wt_q;
    res_empty_q <= emit_empty;
    res_last_q  <= emit_last;
    res_word_q  <= emit_empty ? '0 : best_word;
    res_wt_q    <= emit_empty ? '0 : best_wt;
    res_rank_q  <= emit_empty ? '0 : emit_ext[ptks_pkg::RANK_W-1:0];
  end

  // ranked list of the best matches so far
  ptks_best #(
    .MAX_K (MAX_K),
    .KW    (KW),
    .IW    (IW)
  ) u_best (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (best_ctl),
    .cand_word_i   (m_word_q),
    .cand_weight_i (m_wt_q),
    .k_i           (k_q),
    .rd_idx_i      (emit_q),
    .rd_word_o     (best_word),
    .rd_weight_o   (best_wt),
    .count_o       (best_n)
  );

  assign result_valid_o = res_valid_q;
  assign match_word_o   = res_word_q;
  assign match_weight_o = res_wt_q;
  assign rank_o         = res_rank_q;
  assign empty_result_o = res_empty_q;
  assign last_item_o    = res_last_q;

endmodule

@@ sv/ptks_chk.sv @@
module ptks_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [ptks_pkg::OP_W-1:0]      opcode_i,
  input logic                           result_valid_o,
  input logic [ptks_pkg::WORD_W-1:0]    match_word_o,
  input logic [ptks_pkg::WEIGHT_W-1:0]  match_weight_o,
  input logic [ptks_pkg::RANK_W-1:0]    rank_o,
  input logic                           empty_result_o,
  input logic                           last_item_o
);

  // an accepted query always occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == ptks_pkg::OP_QUERY)) |=> busy_o)
    else $error("query accepted but block not busy");

  // an empty answer is a single zeroed item
  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && empty_result_o) |->
      (last_item_o && (match_word_o == '0) && (match_weight_o == '0) && (rank_o == '0)))
    else $error("empty item not final or not zeroed");

  // items of one query come back to back with rising rank
  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_item_o) |=>
      (result_valid_o && (rank_o == $past(rank_o) + 3'd1)))
    else $error("result items not consecutive");

  // the final item closes the burst
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_item_o) |=> !result_valid_o)
    else $error("item follows the final item");

endmodule

bind prefix_top_k_selector ptks_chk u_ptks_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .opcode_i       (opcode_i),
  .result_valid_o (result_valid_o),
  .match_word_o   (match_word_o),
  .match_weight_o (match_weight_o),
  .rank_o         (rank_o),
  .empty_result_o (empty_result_o),
  .last_item_o    (last_item_o)
);

@@ bench/prefix_top_k_selector_tb.sv @@
module prefix_top_k_selector_tb;

  localparam int MAX_ENTRIES  = 1024;
  localparam int MAX_CHARS    = 8;
  localparam int MAX_K        = 8;
  localparam int LIMIT_CYCLES = 600_000;
  localparam int RAND_CAP     = 64;
  localparam int LenW         = ptks_pkg::LEN_W;
  localparam int WtW          = ptks_pkg::WEIGHT_W;

  // opcode that the block ignores
  localparam logic [ptks_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [ptks_pkg::WEIGHT_W-1:0] WEIGHT_MAX = 31'h7FFF_FFFF;
  localparam logic [ptks_pkg::WORD_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // one suggestion as it leaves the block
  typedef struct packed {
    logic [ptks_pkg::WORD_W-1:0]   word;
    logic [ptks_pkg::WEIGHT_W-1:0] weight;
    logic [ptks_pkg::RANK_W-1:0]   rank;
    logic                          empty;
    logic                          last;
  } suggestion_t;

  // one directed request, with a typed expectation where it is obvious
  typedef struct packed {
    logic [ptks_pkg::OP_W-1:0]     op;
    logic [ptks_pkg::WORD_W-1:0]   text;
    logic [ptks_pkg::LEN_W-1:0]    len;
    logic [ptks_pkg::WEIGHT_W-1:0] wt;
    logic                          typed;
    suggestion_t                   want;
  } request_t;

  localparam suggestion_t NO_MATCH = '{word: '0, weight: '0, rank: '0, empty: 1'b1, last: 1'b1};
  localparam suggestion_t ANY = '0;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ptks_pkg::TOPK_W-1:0]   cfg_wdata_i;
  logic                          start_i;
  logic                          busy_o;
  logic [ptks_pkg::OP_W-1:0]     opcode_i;
  logic [ptks_pkg::WORD_W-1:0]   text_i;
  logic [ptks_pkg::LEN_W-1:0]    text_len_i;
  logic [ptks_pkg::WEIGHT_W-1:0] weight_i;
  logic                          result_valid_o;
  logic [ptks_pkg::WORD_W-1:0]   match_word_o;
  logic [ptks_pkg::WEIGHT_W-1:0] match_weight_o;
  logic [ptks_pkg::RANK_W-1:0]   rank_o;
  logic                          empty_result_o;
  logic                          last_item_o;

  // dictionary mirror and current suggestion limit
  logic [ptks_pkg::WORD_W-1:0]   dict_word   [MAX_ENTRIES];
  logic [ptks_pkg::WEIGHT_W-1:0] dict_weight [MAX_ENTRIES];
  int unsigned                   dict_count;
  logic [ptks_pkg::TOPK_W-1:0]   k_limit;

  suggestion_t due_suggestions[$];
  int unsigned items_accepted;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycle_count;

  request_t directed_requests [24] = '{
    '{ptks_pkg::OP_QUERY,  {"a", 56'h0},        4'd1,  31'd0,      1'b1, NO_MATCH},
    '{ptks_pkg::OP_QUERY,  64'h0,               4'd0,  31'd0,      1'b1, NO_MATCH},
    '{ptks_pkg::OP_APPEND, {"apple", 24'h0},    4'd5,  31'd100,    1'b0, ANY},
    '{ptks_pkg::OP_APPEND, {"app", 40'h0},      4'd3,  31'd100,    1'b0, ANY},
    '{ptks_pkg::OP_APPEND, {"apply", 24'h0},    4'd5,  WEIGHT_MAX, 1'b0, ANY},
    '{ptks_pkg::OP_APPEND, {"banana", 16'h0},   4'd6,  31'd0,      1'b0, ANY},
    '{ptks_pkg::OP_APPEND, ALL_ONES,            4'd8,  31'd5,      1'b0, ANY},
    '{ptks_pkg::OP_APPEND, 64'h0,               4'd0,  31'd7,      1'b0, ANY},
    '{ptks_pkg::OP_APPEND, {"apple", 24'h0},    4'd5,  31'd100,    1'b0, ANY},
    '{ptks_pkg::OP_APPEND, {"apt", 40'h0},      4'd15, 31'd100,    1'b0, ANY},
    '{ptks_pkg::OP_APPEND, {"ape", 40'h0},      4'd3,  31'd1,      1'b0, ANY},
    '{ptks_pkg::OP_QUERY,  {"ap", 48'h0},       4'd2,  31'd0,      1'b0, ANY},
    '{ptks_pkg::OP_QUERY,  {"appl", 32'hDEAD_BEEF}, 4'd4, 31'd0,   1'b0, ANY},
    '{ptks_pkg::OP_QUERY,  "bzzzzzzz",          4'd1,  31'd0,      1'b0, ANY},
    '{ptks_pkg::OP_QUERY,  ALL_ONES,            4'd15, 31'd0,      1'b0, ANY},
    '{ptks_pkg::OP_QUERY,  64'h0,               4'd8,  31'd0,      1'b0, ANY},
    '{ptks_pkg::OP_QUERY,  {"q", 56'h0},        4'd1,  31'd0,      1'b1, NO_MATCH},
    '{ptks_pkg::OP_QUERY,  {"ap", 48'h0},       4'd0,  31'd0,      1'b1, NO_MATCH},
    '{OP_UNUSED,           {"apple", 24'h0},    4'd5,  31'd9,      1'b0, ANY},
    '{ptks_pkg::OP_CLEAR,  64'h0,               4'd0,  31'd0,      1'b0, ANY},
    '{ptks_pkg::OP_QUERY,  {"a", 56'h0},        4'd1,  31'd0,      1'b1, NO_MATCH},
    '{ptks_pkg::OP_APPEND, {"cat", 40'h0},      4'd0,  31'd3,      1'b0, ANY},
    '{ptks_pkg::OP_QUERY,  {"c", 56'h0},        4'd1,  31'd0,      1'b1,
      '{word: {"cat", 40'h0}, weight: 31'd3, rank: 3'd0, empty: 1'b0, last: 1'b1}},
    '{ptks_pkg::OP_QUERY,  {"cat", 40'h0},      4'd3,  WEIGHT_MAX, 1'b0, ANY}
  };

  prefix_top_k_selector #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_CHARS  (MAX_CHARS),
    .MAX_K      (MAX_K)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .text_i        (text_i),
    .text_len_i    (text_len_i),
    .weight_i      (weight_i),
    .result_valid_o(result_valid_o),
    .match_word_o  (match_word_o),
    .match_weight_o(match_weight_o),
    .rank_o        (rank_o),
    .empty_result_o(empty_result_o),
    .last_item_o   (last_item_o)
  );

  always #2 clk_i = ~clk_i;

  // true when (fa, wa) comes strictly before (fb, wb)
  function automatic bit outranks(input logic [ptks_pkg::WEIGHT_W-1:0] fa,
                                  input logic [ptks_pkg::WORD_W-1:0]   wa,
                                  input logic [ptks_pkg::WEIGHT_W-1:0] fb,
                                  input logic [ptks_pkg::WORD_W-1:0]   wb);
    if (fa != fb) return fa > fb;
    return wa < wb;
  endfunction

  // queue one expected suggestion behind those already due
  function automatic void queue_suggestion(input suggestion_t s);
    due_suggestions = {due_suggestions, s};
  endfunction

  // update the dictionary mirror and queue the suggestions an item produces
  task automatic compute_suggestions(input logic [ptks_pkg::OP_W-1:0]     op,
                                     input logic [ptks_pkg::WORD_W-1:0]   txt,
                                     input logic [ptks_pkg::LEN_W-1:0]    len,
                                     input logic [ptks_pkg::WEIGHT_W-1:0] wt);
    logic [ptks_pkg::WORD_W-1:0]   top_word   [MAX_K];
    logic [ptks_pkg::WEIGHT_W-1:0] top_weight [MAX_K];
    logic [ptks_pkg::WORD_W-1:0]   mask;
    int unsigned                   held, k, chars, pos;
    suggestion_t                   s;
    case (op)
      ptks_pkg::OP_CLEAR: begin
        dict_count = 0;
      end
      ptks_pkg::OP_APPEND: begin
        // appends past the end of the store are dropped
        if (dict_count < MAX_ENTRIES) begin
          dict_word[dict_count]   = txt;
          dict_weight[dict_count] = wt;
          dict_count++;
        end
      end
      ptks_pkg::OP_QUERY: begin
        held  = 0;
        k     = (k_limit > MAX_K) ? MAX_K : k_limit;
        chars = (len > MAX_CHARS) ? MAX_CHARS : len;
        mask  = ~(ALL_ONES >> (8 * chars));
        if (chars != 0 && k != 0) begin
          for (int i = 0; i < dict_count; i++) begin
            if (((dict_word[i] ^ txt) & mask) == '0 &&
                (held < k || outranks(dict_weight[i], dict_word[i],
                                      top_weight[k-1], top_word[k-1]))) begin
              if (held >= k) held = k - 1;
              pos = held;
              while (pos > 0 && outranks(dict_weight[i], dict_word[i],
                                         top_weight[pos-1], top_word[pos-1])) begin
                top_word[pos]   = top_word[pos-1];
                top_weight[pos] = top_weight[pos-1];
                pos--;
              end
              top_word[pos]   = dict_word[i];
              top_weight[pos] = dict_weight[i];
              held++;
            end
          end
        end
        if (held == 0) begin
          queue_suggestion(NO_MATCH);
        end else begin
          for (int i = 0; i < held; i++) begin
            s.word   = top_word[i];
            s.weight = top_weight[i];
            s.rank   = i[ptks_pkg::RANK_W-1:0];
            s.empty  = 1'b0;
            s.last   = (i + 1 == held);
            queue_suggestion(s);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // hand one item to the block, with random gaps ahead of it
  task automatic send_item(input logic [ptks_pkg::OP_W-1:0]     op,
                           input logic [ptks_pkg::WORD_W-1:0]   txt,
                           input logic [ptks_pkg::LEN_W-1:0]    len,
                           input logic [ptks_pkg::WEIGHT_W-1:0] wt,
                           input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    opcode_i   <= op;
    text_i     <= txt;
    text_len_i <= len;
    weight_i   <= wt;
    do @(posedge clk_i); while (busy_o);
    items_accepted++;
  endtask

  // write top_k once the block has drained
  task automatic set_top_k(input logic [ptks_pkg::TOPK_W-1:0] value);
    while (due_suggestions.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    k_limit = value;
    cfg_we_i <= 1'b0;
  endtask

  // mostly short words over a tiny alphabet so that prefixes collide
  function automatic logic [ptks_pkg::WORD_W-1:0] random_word();
    int unsigned                 nchars, mode;
    logic [7:0]                  ch;
    logic [ptks_pkg::WORD_W-1:0] w;
    if ($urandom_range(0, 19) == 0) return {$urandom, $urandom};
    nchars = $urandom_range(1, MAX_CHARS);
    w = '0;
    for (int i = 0; i < nchars; i++) begin
      mode = $urandom_range(0, 99);
      if (mode < 80) ch = 8'(8'h61 + $urandom_range(0, 3));
      else if (mode < 95) ch = 8'($urandom_range(8'h20, 8'h7E));
      else ch = 8'($urandom_range(1, 255));
      w[ptks_pkg::WORD_W-1-8*i -: 8] = ch;
    end
    return w;
  endfunction

  // small weights give plenty of ties
  function automatic logic [ptks_pkg::WEIGHT_W-1:0] random_weight();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return WtW'($urandom_range(0, 15));
    if (roll < 90) return WtW'($urandom);
    return roll[0] ? WEIGHT_MAX : '0;
  endfunction

  // a prefix of a stored word, bytes past the prefix sometimes scrambled
  function automatic logic [ptks_pkg::WORD_W-1:0] stored_prefix(input int unsigned chars);
    logic [ptks_pkg::WORD_W-1:0] w, tail;
    w    = dict_word[$urandom_range(0, dict_count - 1)];
    tail = ALL_ONES >> (8 * chars);
    if ($urandom_range(0, 1)) w = (w & ~tail) | ({$urandom, $urandom} & tail);
    return w;
  endfunction

  // one random item: mostly appends and prefix queries, some clears and noise
  task automatic random_item(input int unsigned idle_pct, output bit counted);
    int unsigned                   roll, chars;
    logic [ptks_pkg::OP_W-1:0]     op;
    logic [ptks_pkg::WORD_W-1:0]   txt;
    logic [ptks_pkg::LEN_W-1:0]    len;
    logic [ptks_pkg::WEIGHT_W-1:0] wt;
    roll = $urandom_range(0, 99);
    txt  = random_word();
    len  = LenW'($urandom_range(0, 15));
    wt   = random_weight();
    if (roll < 3) begin
      op = ptks_pkg::OP_CLEAR;
    end else if (roll < 6) begin
      op = OP_UNUSED;
    end else if (roll < 50 && dict_count < RAND_CAP) begin
      op = ptks_pkg::OP_APPEND;
    end else begin
      op = ptks_pkg::OP_QUERY;
      if (dict_count != 0 && $urandom_range(0, 99) < 85) begin
        chars = $urandom_range(1, MAX_CHARS);
        txt   = stored_prefix(chars);
        len   = LenW'(chars);
      end
    end
    counted = (op != OP_UNUSED);
    // now and then let every pending suggestion come out first
    if ($urandom_range(0, 39) == 0) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while (due_suggestions.size() != 0);
    end
    send_item(op, txt, len, wt, idle_pct);
    compute_suggestions(op, txt, len, wt);
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned idle_pct);
    int unsigned done;
    bit          counted;
    done = 0;
    while (done < n) begin
      random_item(idle_pct, counted);
      if (counted) done++;
    end
    start_i <= 1'b0;
  endtask

  // compare every suggestion against the oldest one still due
  always @(posedge clk_i) begin : check_results
    suggestion_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (due_suggestions.size() == 0) begin
        $error("unexpected suggestion: word %h weight %0d", match_word_o, match_weight_o);
        mismatches++;
      end else begin
        want = due_suggestions.pop_front();
        if (match_word_o !== want.word) begin
          $error("match_word: expected %h, got %h", want.word, match_word_o);
          mismatches++;
        end
        if (match_weight_o !== want.weight) begin
          $error("match_weight: expected %0d, got %0d", want.weight, match_weight_o);
          mismatches++;
        end
        if (rank_o !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, rank_o);
          mismatches++;
        end
        if (empty_result_o !== want.empty) begin
          $error("empty_result: expected %0b, got %0b", want.empty, empty_result_o);
          mismatches++;
        end
        if (last_item_o !== want.last) begin
          $error("last_item: expected %0b, got %0b", want.last, last_item_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d suggestions still due",
             cycle_count, due_suggestions.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    start_i     <= 1'b0;
    opcode_i    <= ptks_pkg::OP_CLEAR;
    text_i      <= '0;
    text_len_i  <= '0;
    weight_i    <= '0;
    dict_count     = 0;
    k_limit        = ptks_pkg::TOPK_RESET;
    items_accepted = 0;
    results_seen   = 0;
    mismatches     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset value of top_k
    for (int r = 0; r < $size(directed_requests); r++) begin
      send_item(directed_requests[r].op, directed_requests[r].text,
                directed_requests[r].len, directed_requests[r].wt, 0);
      if (directed_requests[r].typed) queue_suggestion(directed_requests[r].want);
      else compute_suggestions(directed_requests[r].op, directed_requests[r].text,
                               directed_requests[r].len, directed_requests[r].wt);
    end
    start_i <= 1'b0;

    // random traffic under several top_k settings, including one above the list depth
    set_top_k(4'd15);
    random_phase(50, 10);
    set_top_k(4'd1);
    random_phase(50, 10);
    set_top_k(4'd8);
    random_phase(60, 74);
    set_top_k(4'd0);
    random_phase(20, 0);
    set_top_k(4'd3);
    random_phase(70, 0);

    while (due_suggestions.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("run covered %0d items: a directed table, then random appends, clears,",
             items_accepted);
    $display("unused opcodes and prefix queries; %0d suggestions checked at top_k 5, 15, 1, 8, 0, 3",
             results_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ prefix_top_k_selector.f @@
sv/ptks_pkg.sv
sv/ptks_best.sv
sv/prefix_top_k_selector.sv
sv/ptks_chk.sv
bench/prefix_top_k_selector_tb.sv
